>>> hdl/open_addressing_hash_table_unit_assert.svh
// assertion macros for the open addressing hash table unit
// included by modules that check their own sequencing
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define OAHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oaht assertion failed");
`define OAHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oaht assertion failed");
`else
`define OAHT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OAHT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/oaht_pkg.sv
// shared types, codes and constants of the open addressing hash table unit
// no dependencies
package oaht_pkg;

  localparam int DEPTH      = 1024;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CAP_W      = 11;
  localparam int KEY_W      = 64;
  localparam int CMD_W      = 3;
  localparam int ROUND_W    = 4;
  localparam int MIX_ROUNDS = 12;
  localparam int DIV_W      = 6;
  localparam int DIV_STEPS  = 64;

  localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DEPTH);

  localparam logic [KEY_W-1:0] KEY_EMPTY   = '0;
  localparam logic [KEY_W-1:0] KEY_TOMB    = '1;
  localparam logic [KEY_W-1:0] HASH_LEVEL  = 64'h0000_0000_DEAD_BEEF;
  localparam logic [KEY_W-1:0] HASH_INIT_C = 64'h9E37_79B9_7F4A_7C14;

  localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_END      = 3'd4
  } status_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [CAP_W-1:0] cap;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] pos;
  } hash_rsp_t;

  // shift amount of each mix round
  function automatic logic [5:0] mix_shift(input logic [ROUND_W-1:0] rnd);
    logic [5:0] s;
    case (rnd)
      4'd0:    s = 6'd43;
      4'd1:    s = 6'd9;
      4'd2:    s = 6'd8;
      4'd3:    s = 6'd38;
      4'd4:    s = 6'd23;
      4'd5:    s = 6'd5;
      4'd6:    s = 6'd35;
      4'd7:    s = 6'd49;
      4'd8:    s = 6'd11;
      4'd9:    s = 6'd12;
      4'd10:   s = 6'd18;
      4'd11:   s = 6'd22;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/oaht_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module oaht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/oaht_hash.sv
// iterative key hash: twelve mix rounds on one shared subtract/xor/shift unit,
// then a bit-serial remainder by the capacity in use; uses oaht_pkg
module oaht_hash (
  input  logic               clk,
  input  logic               rst_n,
  input  oaht_pkg::hash_req_t req,
  output oaht_pkg::hash_rsp_t rsp
);

  typedef enum logic [1:0] {H_IDLE, H_MIX, H_MOD} hstate_t;

  hstate_t                        state_r, state_nxt;
  logic [oaht_pkg::KEY_W-1:0]     x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [oaht_pkg::ROUND_W-1:0]   round_r, round_nxt;
  logic [1:0]                     ph_r, ph_nxt;
  logic [oaht_pkg::DIV_W-1:0]     div_r, div_nxt;
  logic [oaht_pkg::CAP_W-1:0]     rem_r, rem_nxt;
  logic [oaht_pkg::CAP_W-1:0]     cap_r, cap_nxt;
  logic                           done_r, done_nxt;
  logic [oaht_pkg::KEY_W-1:0]     mixed, shifted;
  logic [5:0]                     sh;
  logic [oaht_pkg::CAP_W:0]       rem_sh;

  // shared unit: t = (t - p - q) ^ shift(q), operands rotate every round
  always_comb begin
    sh      = oaht_pkg::mix_shift(round_r);
    shifted = (ph_r == 2'd1) ? (z_r << sh) : (z_r >> sh);
    mixed   = (x_r - y_r - z_r) ^ shifted;
    rem_sh  = {rem_r, z_r[oaht_pkg::KEY_W-1]};
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    round_nxt = round_r;
    ph_nxt    = ph_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    cap_nxt   = cap_r;
    done_nxt  = 1'b0;
    case (state_r)
      H_IDLE: begin
        if (req.start) begin
          x_nxt     = oaht_pkg::HASH_LEVEL + req.key;
          y_nxt     = oaht_pkg::HASH_LEVEL;
          z_nxt     = oaht_pkg::HASH_INIT_C;
          cap_nxt   = req.cap;
          round_nxt = '0;
          ph_nxt    = 2'd0;
          state_nxt = H_MIX;
        end
      end
      H_MIX: begin
        x_nxt     = y_r;
        y_nxt     = z_r;
        z_nxt     = mixed;
        round_nxt = round_r + 1'b1;
        ph_nxt    = (ph_r == 2'd2) ? 2'd0 : ph_r + 2'd1;
        if (round_r == oaht_pkg::ROUND_W'(oaht_pkg::MIX_ROUNDS - 1)) begin
          div_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = H_MOD;
        end
      end
      H_MOD: begin
        // remainder stays below cap, so one compare and subtract per bit
        if (rem_sh >= {1'b0, cap_r}) begin
          rem_nxt = oaht_pkg::CAP_W'(rem_sh - {1'b0, cap_r});
        end else begin
          rem_nxt = oaht_pkg::CAP_W'(rem_sh);
        end
        z_nxt   = {z_r[oaht_pkg::KEY_W-2:0], 1'b0};
        div_nxt = div_r + 1'b1;
        if (div_r == oaht_pkg::DIV_W'(oaht_pkg::DIV_STEPS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    round_r <= round_nxt;
    ph_r    <= ph_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    cap_r   <= cap_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.pos  = rem_r[oaht_pkg::IDX_W-1:0];

endmodule

>>> hdl/open_addressing_hash_table_unit.sv
// top level of the open addressing hash table unit: command sequencer,
// key and value rams, hash unit; uses oaht_pkg, oaht_ram, oaht_hash
//
//  channel | ports                                      | direction
//  in      | in_valid in_ready in_cmd in_key in_value   | command transaction in
//  out     | out_valid out_ready out_status             | result transaction out
//          | out_found_key out_found_value              |
//  cfg     | cfg_we cfg_wdata                           | capacity register write
//
// put/get/delete: the key is hashed (12 mix rounds and 64 remainder bits on the
// shared hash unit, then the slot is handed over), then each probed slot is
// read from the key ram and then checked, and the result goes out. iterator next:
// each slot scanned is read and then checked; restart and rejects go to S_RESP.
// after reset all 1024 key ram slots are cleared, one slot a cycle; no
// command is taken meanwhile. a waiting result holds the sequencer in its
// response state, so at most one more command is taken while it waits.
module open_addressing_hash_table_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [oaht_pkg::CMD_W-1:0]   in_cmd,
  input  logic [oaht_pkg::KEY_W-1:0]   in_key,
  input  logic [oaht_pkg::KEY_W-1:0]   in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [oaht_pkg::KEY_W-1:0]   out_found_key,
  output logic [oaht_pkg::KEY_W-1:0]   out_found_value,
  input  logic                         cfg_we,
  input  logic [oaht_pkg::CAP_W-1:0]   cfg_wdata
);

  `include "open_addressing_hash_table_unit_assert.svh"

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_CHK, S_ITER_RD, S_ITER_CHK, S_RESP
  } state_t;

  localparam int IW = oaht_pkg::IDX_W;
  localparam int CW = oaht_pkg::CAP_W;
  localparam int KW = oaht_pkg::KEY_W;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          cap_r;
  logic [CW-1:0]          capu;
  logic [IW-1:0]          clr_r, clr_nxt;
  logic [oaht_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [KW-1:0]          key_r, key_nxt, val_r, val_nxt;
  logic [IW-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   tomb_v_r, tomb_v_nxt;
  logic [IW-1:0]          tomb_r, tomb_nxt;
  logic [CW-1:0]          live_r, live_nxt;
  logic [CW-1:0]          iter_r, iter_nxt;
  logic [CW-1:0]          scan_r, scan_nxt;
  oaht_pkg::status_t      res_st_r, res_st_nxt;
  logic [KW-1:0]          res_key_r, res_key_nxt, res_val_r, res_val_nxt;
  logic                   out_valid_r, out_valid_nxt;
  oaht_pkg::status_t      out_st_r, out_st_nxt;
  logic [KW-1:0]          out_key_r, out_key_nxt, out_val_r, out_val_nxt;

  logic                   kwe, vwe;
  logic [IW-1:0]          kwaddr, vwaddr, raddr;
  logic [KW-1:0]          kwdata, vwdata, krdata, vrdata;
  oaht_pkg::hash_req_t    hreq;
  oaht_pkg::hash_rsp_t    hrsp;

  logic                   bad_key, is_tomb, tomb_any, walk_end, pos_wrap, scan_end;
  logic [IW-1:0]          tomb_any_idx;
  logic [CW-1:0]          pos_inc, cnt_inc, scan_inc;

  always_comb begin
    if (cap_r == '0) begin
      capu = CW'(1);
    end else if (cap_r > oaht_pkg::DEPTH_CAP) begin
      capu = oaht_pkg::DEPTH_CAP;
    end else begin
      capu = cap_r;
    end
  end

  oaht_ram #(.WIDTH(KW), .DEPTH(oaht_pkg::DEPTH)) u_key_ram (
    .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata), .raddr(raddr), .rdata(krdata)
  );

  oaht_ram #(.WIDTH(KW), .DEPTH(oaht_pkg::DEPTH)) u_val_ram (
    .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata), .raddr(raddr), .rdata(vrdata)
  );

  oaht_hash u_hash (.clk(clk), .rst_n(rst_n), .req(hreq), .rsp(hrsp));

  assign in_ready  = (state_r == S_IDLE);
  assign bad_key   = (in_key == oaht_pkg::KEY_EMPTY) || (in_key == oaht_pkg::KEY_TOMB);
  assign is_tomb   = (krdata == oaht_pkg::KEY_TOMB);
  assign tomb_any  = tomb_v_r || is_tomb;
  assign tomb_any_idx = tomb_v_r ? tomb_r : pos_r;
  assign pos_inc   = {1'b0, pos_r} + CW'(1);
  assign pos_wrap  = (pos_inc == capu);
  assign cnt_inc   = cnt_r + CW'(1);
  assign walk_end  = (cnt_inc == capu);
  assign scan_inc  = scan_r + CW'(1);
  assign scan_end  = (scan_inc >= capu);

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    tomb_v_nxt  = tomb_v_r;
    tomb_nxt    = tomb_r;
    live_nxt    = live_r;
    iter_nxt    = iter_r;
    scan_nxt    = scan_r;
    res_st_nxt  = res_st_r;
    res_key_nxt = res_key_r;
    res_val_nxt = res_val_r;
    kwe         = 1'b0;
    kwaddr      = pos_r;
    kwdata      = key_r;
    vwe         = 1'b0;
    vwaddr      = pos_r;
    vwdata      = val_r;
    raddr       = pos_r;
    hreq.start  = 1'b0;
    hreq.key    = key_r;
    hreq.cap    = capu;

    // output register frees as soon as its transaction completes
    out_valid_nxt = out_valid_r && !out_ready;
    out_st_nxt    = out_st_r;
    out_key_nxt   = out_key_r;
    out_val_nxt   = out_val_r;

    case (state_r)
      S_CLEAR: begin
        kwe    = 1'b1;
        kwaddr = clr_r;
        kwdata = oaht_pkg::KEY_EMPTY;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IW'(oaht_pkg::DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_cmd;
          key_nxt     = in_key;
          val_nxt     = in_value;
          res_st_nxt  = oaht_pkg::ST_OK;
          res_key_nxt = '0;
          res_val_nxt = '0;
          state_nxt   = S_RESP;
          if ((in_cmd == oaht_pkg::CMD_PUT || in_cmd == oaht_pkg::CMD_GET ||
               in_cmd == oaht_pkg::CMD_DEL) && bad_key) begin
            res_st_nxt = oaht_pkg::ST_INVALID;
          end else if (in_cmd == oaht_pkg::CMD_PUT || in_cmd == oaht_pkg::CMD_GET ||
                       in_cmd == oaht_pkg::CMD_DEL) begin
            hreq.start = 1'b1;
            hreq.key   = in_key;
            state_nxt  = S_HASH;
          end else if (in_cmd == oaht_pkg::CMD_RESTART) begin
            iter_nxt = '0;
          end else if (in_cmd == oaht_pkg::CMD_NEXT) begin
            if (iter_r >= capu) begin
              res_st_nxt = oaht_pkg::ST_END;
            end else begin
              scan_nxt  = iter_r;
              state_nxt = S_ITER_RD;
            end
          end
        end
      end
      S_HASH: begin
        if (hrsp.done) begin
          pos_nxt    = hrsp.pos;
          cnt_nxt    = '0;
          tomb_v_nxt = 1'b0;
          state_nxt  = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        raddr     = pos_r;
        state_nxt = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        state_nxt = S_RESP;
        if (krdata == key_r) begin
          if (cmd_r == oaht_pkg::CMD_PUT) begin
            vwe = 1'b1;
          end else if (cmd_r == oaht_pkg::CMD_GET) begin
            res_val_nxt = vrdata;
          end else begin
            kwe      = 1'b1;
            kwdata   = oaht_pkg::KEY_TOMB;
            vwe      = 1'b1;
            vwdata   = '0;
            live_nxt = (live_r == '0) ? live_r : live_r - CW'(1);
          end
        end else if (krdata == oaht_pkg::KEY_EMPTY || walk_end) begin
          // probe walk over: a miss
          if (cmd_r == oaht_pkg::CMD_PUT) begin
            if (live_r >= capu) begin
              res_st_nxt = oaht_pkg::ST_NOSPACE;
            end else if (tomb_any) begin
              kwe = 1'b1; kwaddr = tomb_any_idx;
              vwe = 1'b1; vwaddr = tomb_any_idx;
              live_nxt = live_r + CW'(1);
            end else if (krdata == oaht_pkg::KEY_EMPTY) begin
              kwe = 1'b1;
              vwe = 1'b1;
              live_nxt = live_r + CW'(1);
            end else begin
              res_st_nxt = oaht_pkg::ST_NOSPACE;
            end
          end else begin
            res_st_nxt = oaht_pkg::ST_NOTFOUND;
          end
        end else begin
          if (is_tomb && !tomb_v_r) begin
            tomb_v_nxt = 1'b1;
            tomb_nxt   = pos_r;
          end
          pos_nxt   = pos_wrap ? '0 : pos_inc[IW-1:0];
          cnt_nxt   = cnt_inc;
          state_nxt = S_PROBE_RD;
        end
      end
      S_ITER_RD: begin
        raddr     = scan_r[IW-1:0];
        state_nxt = S_ITER_CHK;
      end
      S_ITER_CHK: begin
        if (krdata != oaht_pkg::KEY_EMPTY && !is_tomb) begin
          res_key_nxt = krdata;
          res_val_nxt = vrdata;
          iter_nxt    = scan_inc;
          state_nxt   = S_RESP;
        end else if (scan_end) begin
          res_st_nxt = oaht_pkg::ST_END;
          state_nxt  = S_RESP;
        end else begin
          scan_nxt  = scan_inc;
          state_nxt = S_ITER_RD;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_key_nxt   = res_key_r;
          out_val_nxt   = res_val_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      live_r      <= '0;
      iter_r      <= '0;
      cap_r       <= oaht_pkg::DEPTH_CAP;
      out_valid_r <= 1'b0;
      tomb_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      live_r      <= live_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
      tomb_v_r    <= tomb_v_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    cnt_r     <= cnt_nxt;
    tomb_r    <= tomb_nxt;
    scan_r    <= scan_nxt;
    res_st_r  <= res_st_nxt;
    res_key_r <= res_key_nxt;
    res_val_r <= res_val_nxt;
    out_st_r  <= out_st_nxt;
    out_key_r <= out_key_nxt;
    out_val_r <= out_val_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_found_key   = out_key_r;
  assign out_found_value = out_val_r;

  `OAHT_ASSERT_IMP(a_hash_done_when_waiting, clk, rst_n, hrsp.done, state_r == S_HASH)
  `OAHT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `OAHT_ASSERT_IMP(a_probe_in_range, clk, rst_n, state_r == S_PROBE_CHK, CW'(pos_r) < capu)
  `OAHT_ASSERT_IMP(a_walk_bounded, clk, rst_n, state_r == S_PROBE_RD, cnt_r < capu)

endmodule
